[rtl/rtc_pkg.sv]
// Shared types, codes and matcher functions for the token classifier.
package rtc_pkg;

  // Token type codes carried on the result word
  localparam logic [3:0] TOK_NULL         = 4'd0;
  localparam logic [3:0] TOK_STRING       = 4'd1;
  localparam logic [3:0] TOK_INT          = 4'd2;
  localparam logic [3:0] TOK_IDEN         = 4'd3;
  localparam logic [3:0] TOK_CALL         = 4'd4;
  localparam logic [3:0] TOK_OPER         = 4'd5;
  localparam logic [3:0] TOK_METHOD_DECL  = 4'd6;
  localparam logic [3:0] TOK_END          = 4'd7;
  localparam logic [3:0] TOK_LOC_VAR_SET  = 4'd8;
  localparam logic [3:0] TOK_GLB_VAR_SET  = 4'd9;
  localparam logic [3:0] TOK_LOC_VAR_DECL = 4'd10;
  localparam logic [3:0] TOK_GLB_VAR_DECL = 4'd11;
  localparam logic [3:0] TOK_GLB_IDEN     = 4'd12;

  // Integer literal matcher
  typedef enum logic [2:0] {
    INT_START = 3'b001,
    INT_ACC   = 3'b010,
    INT_DEAD  = 3'b100
  } int_st_t;

  // Identifier matcher phase
  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_BODY   = 4'b0010,
    PH_TAIL   = 4'b0100,
    PH_DEAD   = 4'b1000
  } id_phase_t;

  // Identifier prefix seen before the name
  typedef enum logic [5:0] {
    KIND_NONE      = 6'b000001,
    KIND_PCT       = 6'b000010,
    KIND_EQ        = 6'b000100,
    KIND_EQ_DOLLAR = 6'b001000,
    KIND_DOLLAR    = 6'b010000,
    KIND_DOT       = 6'b100000
  } id_kind_t;

  // Keyword "end" matcher
  typedef enum logic [4:0] {
    END_0    = 5'b00001,
    END_1    = 5'b00010,
    END_2    = 5'b00100,
    END_3    = 5'b01000,
    END_DEAD = 5'b10000
  } end_st_t;

  // Operator matcher
  typedef enum logic [4:0] {
    OP_START = 5'b00001,
    OP_ONE   = 5'b00010,
    OP_PEND  = 5'b00100,
    OP_TWO   = 5'b01000,
    OP_DEAD  = 5'b10000
  } op_st_t;

  typedef struct packed {
    int_st_t   int_st;
    id_phase_t id_phase;
    id_kind_t  id_kind;
    end_st_t   end_st;
    op_st_t    op_st;
  } tracker_t;

  localparam tracker_t TRACKER_INIT = '{
    int_st:   INT_START,
    id_phase: PH_PREFIX,
    id_kind:  KIND_NONE,
    end_st:   END_0,
    op_st:    OP_START
  };

  // Decoded character word passed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ws;
    logic       quote;
    logic       bslash;
    logic       digit;
    logic       head;
    logic       op1;
    logic       op2;
    logic       eq;
    logic       dollar;
    logic       pct;
    logic       dot;
    logic       chr_e;
    logic       chr_n;
    logic       chr_d;
  } char_class_t;

  typedef struct packed {
    logic        push;
    char_class_t word;
  } fifo_wr_t;

  typedef struct packed {
    logic        valid;
    char_class_t word;
  } fifo_head_t;

  // Advance every matcher by one character
  function automatic tracker_t tracker_feed(tracker_t t, char_class_t c);
    tracker_t n;
    n = t;
    if (t.int_st != INT_DEAD) begin
      n.int_st = c.digit ? INT_ACC : INT_DEAD;
    end

    unique case (t.end_st)
      END_0:   n.end_st = c.chr_e ? END_1 : END_DEAD;
      END_1:   n.end_st = c.chr_n ? END_2 : END_DEAD;
      END_2:   n.end_st = c.chr_d ? END_3 : END_DEAD;
      default: n.end_st = END_DEAD;
    endcase

    if (t.op_st == OP_START) begin
      n.op_st = c.op1 ? OP_ONE : (c.op2 ? OP_PEND : OP_DEAD);
    end else if (t.op_st == OP_PEND && c.eq) begin
      n.op_st = OP_TWO;
    end else begin
      n.op_st = OP_DEAD;
    end

    unique case (t.id_phase)
      PH_PREFIX: begin
        priority if (c.head) begin
          n.id_phase = PH_BODY;
        end else if (t.id_kind == KIND_NONE && c.pct) begin
          n.id_kind = KIND_PCT;
        end else if (t.id_kind == KIND_NONE && c.eq) begin
          n.id_kind = KIND_EQ;
        end else if (t.id_kind == KIND_NONE && c.dollar) begin
          n.id_kind = KIND_DOLLAR;
        end else if (t.id_kind == KIND_NONE && c.dot) begin
          n.id_kind = KIND_DOT;
        end else if (t.id_kind == KIND_EQ && c.dollar) begin
          n.id_kind = KIND_EQ_DOLLAR;
        end else begin
          n.id_phase = PH_DEAD;
        end
      end
      PH_BODY: begin
        priority if (c.head || c.digit) begin
          n.id_phase = PH_BODY;
        end else if (c.dollar && (t.id_kind == KIND_NONE || t.id_kind == KIND_DOLLAR)) begin
          n.id_phase = PH_TAIL;
        end else begin
          n.id_phase = PH_DEAD;
        end
      end
      default: n.id_phase = PH_DEAD;
    endcase
    return n;
  endfunction

  // Pick the token type by matcher priority
  function automatic logic [3:0] classify(tracker_t t);
    logic [3:0] kind_type;
    unique case (t.id_kind)
      KIND_PCT:       kind_type = TOK_METHOD_DECL;
      KIND_EQ:        kind_type = TOK_LOC_VAR_SET;
      KIND_EQ_DOLLAR: kind_type = TOK_GLB_VAR_SET;
      KIND_DOLLAR:    kind_type = TOK_GLB_IDEN;
      KIND_DOT:       kind_type = TOK_CALL;
      default:        kind_type = TOK_IDEN;
    endcase
    priority if (t.int_st == INT_ACC) begin
      return TOK_INT;
    end else if (t.end_st == END_3) begin
      return TOK_END;
    end else if (t.id_phase == PH_BODY) begin
      return kind_type;
    end else if (t.id_phase == PH_TAIL) begin
      return (t.id_kind == KIND_NONE) ? TOK_LOC_VAR_DECL : TOK_GLB_VAR_DECL;
    end else if (t.op_st == OP_ONE || t.op_st == OP_TWO) begin
      return TOK_OPER;
    end else begin
      return TOK_NULL;
    end
  endfunction

endpackage

[rtl/rtc_ifs.sv]
// Valid/ready channel interfaces for character input and token result.
interface rtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface rtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch_out;
  logic       append;
  logic       token_end;
  logic [3:0] token_type;

  modport source (output valid, output ch_out, output append, output token_end,
                  output token_type, input ready);
  modport sink (input valid, input ch_out, input append, input token_end,
                input token_type, output ready);
endinterface

[rtl/repl_token_classifier.sv]
// Top level of the token classifier: front decode, queue, back end.
//
// Usage:
//   tok_in carries one character word (ch, last) per valid/ready handshake.
//   tok_out returns exactly one result word per character: the echoed
//   character, append, token_end and token_type.
//   A word with last set is followed by an implied newline that may close
//   the open token in the same result word; all state then clears.
// Flow:
//   An accepted character is registered in the queue, then in the result
//   register that drives tok_out. One character per cycle is sustained while
//   tok_out.ready stays high: the queue takes a word while the result register
//   holds one, and the back end updates its matchers once per character.
// Reset (rst, synchronous): the queue empties, tok_out.valid drops and all
//   token and matcher state returns to its start; tok_in.ready is high after.
// Stall: when the receiver holds tok_out.ready low, the result word holds,
//   the queue fills up to FIFO_DEPTH words, then tok_in.ready drops.
module repl_token_classifier #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  rtc_in_if.sink     tok_in,
  rtc_out_if.source  tok_out
);

  rtc_pkg::fifo_wr_t   wr;
  rtc_pkg::fifo_head_t head;
  logic                full;
  logic                pop;

  rtc_front u_front (
    .tok_in (tok_in),
    .full   (full),
    .wr     (wr)
  );

  rtc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  rtc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .tok_out (tok_out)
  );

endmodule

[rtl/rtc_front.sv]
// Front end: accept characters and decode their character classes.
module rtc_front (
  rtc_in_if.sink           tok_in,
  input  logic             full,
  output rtc_pkg::fifo_wr_t wr
);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_D   = 8'h64;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  logic [7:0] c;

  // Take a word whenever the queue has room
  assign tok_in.ready = !full;
  assign c            = tok_in.ch;

  // Decode the character into the flags the back end needs
  always_comb begin
    wr.push        = tok_in.valid && !full;
    wr.word.ch     = c;
    wr.word.last   = tok_in.last;
    wr.word.ws     = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    wr.word.quote  = (c == CH_QUOTE);
    wr.word.bslash = (c == CH_BSLASH);
    wr.word.digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    wr.word.head   = ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
                     ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_UNDER);
    wr.word.op1    = (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_STAR) ||
                     (c == CH_SLASH) || (c == CH_CARET);
    wr.word.op2    = (c == CH_EQ) || (c == CH_BANG) || (c == CH_GT) || (c == CH_LT);
    wr.word.eq     = (c == CH_EQ);
    wr.word.dollar = (c == CH_DOLLAR);
    wr.word.pct    = (c == CH_PCT);
    wr.word.dot    = (c == CH_DOT);
    wr.word.chr_e  = (c == CH_LO_E);
    wr.word.chr_n  = (c == CH_LO_N);
    wr.word.chr_d  = (c == CH_LO_D);
  end

endmodule

[rtl/rtc_fifo.sv]
// Short queue of decoded characters between front and back ends.
module rtc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  rtc_pkg::fifo_wr_t   wr,
  input  logic                pop,
  output logic                full,
  output rtc_pkg::fifo_head_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rtc_pkg::char_class_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.word  = mem[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({wr.push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/rtc_back.sv]
// Back end: token state, matchers and the registered result word.
module rtc_back (
  input  logic                clk,
  input  logic                rst,
  input  rtc_pkg::fifo_head_t head,
  output logic                pop,
  rtc_out_if.source           tok_out
);

  logic             in_string;
  logic             escape_pending;
  logic             string_marked;
  logic             token_open;
  rtc_pkg::tracker_t tracker;

  logic             in_string_next;
  logic             escape_pending_next;
  logic             string_marked_next;
  logic             token_open_next;
  rtc_pkg::tracker_t tracker_next;

  logic             app;
  logic             tend;
  logic [3:0]       ttype;
  logic             out_valid;
  rtc_pkg::char_class_t c;

  assign c   = head.word;
  assign pop = head.valid && (!out_valid || tok_out.ready);

  // Step the token state by one character, then the implied newline on last
  always_comb begin
    in_string_next      = in_string;
    escape_pending_next = escape_pending;
    string_marked_next  = string_marked;
    token_open_next     = token_open;
    tracker_next        = tracker;
    app                 = 1'b0;
    tend                = 1'b0;
    ttype               = rtc_pkg::TOK_NULL;

    if (c.ws && !in_string) begin
      if (token_open) begin
        tend               = 1'b1;
        ttype              = string_marked ? rtc_pkg::TOK_STRING
                                           : rtc_pkg::classify(tracker);
        string_marked_next = 1'b0;
        token_open_next    = 1'b0;
        tracker_next       = rtc_pkg::TRACKER_INIT;
      end
    end else if (c.quote && !escape_pending) begin
      string_marked_next = 1'b1;
      in_string_next     = !in_string;
    end else begin
      if (in_string && c.bslash) begin
        escape_pending_next = 1'b1;
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
      end
      app             = 1'b1;
      token_open_next = 1'b1;
      tracker_next    = rtc_pkg::tracker_feed(tracker, c);
    end

    if (c.last) begin
      if (token_open_next && !in_string_next) begin
        tend  = 1'b1;
        ttype = string_marked_next ? rtc_pkg::TOK_STRING
                                   : rtc_pkg::classify(tracker_next);
      end
      in_string_next      = 1'b0;
      escape_pending_next = 1'b0;
      string_marked_next  = 1'b0;
      token_open_next     = 1'b0;
      tracker_next        = rtc_pkg::TRACKER_INIT;
    end
  end

  // Update state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_string      <= 1'b0;
      escape_pending <= 1'b0;
      string_marked  <= 1'b0;
      token_open     <= 1'b0;
      tracker        <= rtc_pkg::TRACKER_INIT;
      out_valid      <= 1'b0;
    end else if (pop) begin
      in_string      <= in_string_next;
      escape_pending <= escape_pending_next;
      string_marked  <= string_marked_next;
      token_open     <= token_open_next;
      tracker        <= tracker_next;
      out_valid      <= 1'b1;
    end else if (tok_out.ready) begin
      out_valid      <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      tok_out.ch_out     <= c.ch;
      tok_out.append     <= app;
      tok_out.token_end  <= tend;
      tok_out.token_type <= tend ? ttype : rtc_pkg::TOK_NULL;
    end
  end

  assign tok_out.valid = out_valid;

endmodule

[rtl/rtc_checker.sv]
// Port-level checks for the token classifier, bound to the top level.
module rtc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] ch_out,
  input logic       append,
  input logic       token_end,
  input logic [3:0] token_type
);

  logic [7:0] pending;

  // Count words accepted but not yet returned
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      unique case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   pending <= pending + 8'd1;
        2'b01:   pending <= pending - 8'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ch_out) && $stable(append) &&
      $stable(token_end) && $stable(token_type))
    else $error("result word changed while stalled");

  a_type_needs_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !token_end |-> token_type == rtc_pkg::TOK_NULL)
    else $error("token type set without token end");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("result word with no character outstanding");

  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("channels not idle after reset");

endmodule

bind repl_token_classifier rtc_checker u_rtc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (tok_in.valid),
  .in_ready   (tok_in.ready),
  .out_valid  (tok_out.valid),
  .out_ready  (tok_out.ready),
  .ch_out     (tok_out.ch_out),
  .append     (tok_out.append),
  .token_end  (tok_out.token_end),
  .token_type (tok_out.token_type)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for repl_token_classifier: directed and random text, checked word by word.
module testbench;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_LIMIT     = 10000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [7:0] ch_out;
    logic       append;
    logic       token_end;
    logic [3:0] token_type;
  } token_word_t;

  logic clk;
  logic rst;

  rtc_in_if  char_in ();
  rtc_out_if token_out ();

  repl_token_classifier dut (
    .clk     (clk),
    .rst     (rst),
    .tok_in  (char_in),
    .tok_out (token_out)
  );

  // Predictor state: string mode, escape, String mark, open token, matchers
  logic              in_quote;
  logic              escape_next;
  logic              string_seen;
  logic              token_busy;
  rtc_pkg::tracker_t matchers;

  token_word_t expected_words[$];
  logic [7:0]  phrase[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_active;
  event        hold_off_go;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_predictor();
    in_quote    = 1'b0;
    escape_next = 1'b0;
    string_seen = 1'b0;
    token_busy  = 1'b0;
    matchers    = rtc_pkg::TRACKER_INIT;
  endfunction

  // Handle one character: update token state, report append and token close
  function automatic void absorb_char(input logic [7:0] c, output logic joins,
                                      output logic closes, output logic [3:0] kind_code);
    logic              ws;
    logic              digit;
    logic              head;
    logic [3:0]        id_code;
    rtc_pkg::tracker_t t;
    ws     = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    digit  = (c >= "0") && (c <= "9");
    head   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    joins  = 1'b0;
    closes = 1'b0;
    kind_code = rtc_pkg::TOK_NULL;
    t = matchers;
    if (ws && !in_quote) begin
      // Close the open token; a quote anywhere in it wins over the matchers
      if (token_busy) begin
        closes = 1'b1;
        case (t.id_kind)
          rtc_pkg::KIND_PCT:       id_code = rtc_pkg::TOK_METHOD_DECL;
          rtc_pkg::KIND_EQ:        id_code = rtc_pkg::TOK_LOC_VAR_SET;
          rtc_pkg::KIND_EQ_DOLLAR: id_code = rtc_pkg::TOK_GLB_VAR_SET;
          rtc_pkg::KIND_DOLLAR:    id_code = rtc_pkg::TOK_GLB_IDEN;
          rtc_pkg::KIND_DOT:       id_code = rtc_pkg::TOK_CALL;
          default:                 id_code = rtc_pkg::TOK_IDEN;
        endcase
        if (string_seen) begin
          kind_code = rtc_pkg::TOK_STRING;
        end else if (t.int_st == rtc_pkg::INT_ACC) begin
          kind_code = rtc_pkg::TOK_INT;
        end else if (t.end_st == rtc_pkg::END_3) begin
          kind_code = rtc_pkg::TOK_END;
        end else if (t.id_phase == rtc_pkg::PH_BODY) begin
          kind_code = id_code;
        end else if (t.id_phase == rtc_pkg::PH_TAIL) begin
          kind_code = (t.id_kind == rtc_pkg::KIND_NONE) ? rtc_pkg::TOK_LOC_VAR_DECL
                                                        : rtc_pkg::TOK_GLB_VAR_DECL;
        end else if (t.op_st == rtc_pkg::OP_ONE || t.op_st == rtc_pkg::OP_TWO) begin
          kind_code = rtc_pkg::TOK_OPER;
        end
        string_seen = 1'b0;
        token_busy  = 1'b0;
        matchers    = rtc_pkg::TRACKER_INIT;
      end
    end else if (c == CH_QUOTE && !escape_next) begin
      // Toggle string mode and mark the token as a String
      string_seen = 1'b1;
      in_quote    = !in_quote;
    end else begin
      // Append the character; a backslash in a string escapes the next one
      if (in_quote && c == CH_BSLASH) begin
        escape_next = 1'b1;
      end else if (escape_next) begin
        escape_next = 1'b0;
      end
      joins      = 1'b1;
      token_busy = 1'b1;

      // Advance the integer, keyword and operator matchers
      if (t.int_st != rtc_pkg::INT_DEAD) begin
        t.int_st = digit ? rtc_pkg::INT_ACC : rtc_pkg::INT_DEAD;
      end
      case (matchers.end_st)
        rtc_pkg::END_0: t.end_st = (c == "e") ? rtc_pkg::END_1 : rtc_pkg::END_DEAD;
        rtc_pkg::END_1: t.end_st = (c == "n") ? rtc_pkg::END_2 : rtc_pkg::END_DEAD;
        rtc_pkg::END_2: t.end_st = (c == "d") ? rtc_pkg::END_3 : rtc_pkg::END_DEAD;
        default:        t.end_st = rtc_pkg::END_DEAD;
      endcase
      case (matchers.op_st)
        rtc_pkg::OP_START: begin
          if (c == "-" || c == "+" || c == "*" || c == "/" || c == "^") begin
            t.op_st = rtc_pkg::OP_ONE;
          end else if (c == "=" || c == "!" || c == ">" || c == "<") begin
            t.op_st = rtc_pkg::OP_PEND;
          end else begin
            t.op_st = rtc_pkg::OP_DEAD;
          end
        end
        rtc_pkg::OP_PEND: t.op_st = (c == "=") ? rtc_pkg::OP_TWO : rtc_pkg::OP_DEAD;
        default:          t.op_st = rtc_pkg::OP_DEAD;
      endcase

      // Advance the identifier matcher: prefix, name body, trailing dollar
      case (matchers.id_phase)
        rtc_pkg::PH_PREFIX: begin
          if (head) begin
            t.id_phase = rtc_pkg::PH_BODY;
          end else if (matchers.id_kind == rtc_pkg::KIND_NONE && c == "%") begin
            t.id_kind = rtc_pkg::KIND_PCT;
          end else if (matchers.id_kind == rtc_pkg::KIND_NONE && c == "=") begin
            t.id_kind = rtc_pkg::KIND_EQ;
          end else if (matchers.id_kind == rtc_pkg::KIND_NONE && c == "$") begin
            t.id_kind = rtc_pkg::KIND_DOLLAR;
          end else if (matchers.id_kind == rtc_pkg::KIND_NONE && c == ".") begin
            t.id_kind = rtc_pkg::KIND_DOT;
          end else if (matchers.id_kind == rtc_pkg::KIND_EQ && c == "$") begin
            t.id_kind = rtc_pkg::KIND_EQ_DOLLAR;
          end else begin
            t.id_phase = rtc_pkg::PH_DEAD;
          end
        end
        rtc_pkg::PH_BODY: begin
          if (head || digit) begin
            t.id_phase = rtc_pkg::PH_BODY;
          end else if (c == "$" &&
                       (matchers.id_kind == rtc_pkg::KIND_NONE ||
                        matchers.id_kind == rtc_pkg::KIND_DOLLAR)) begin
            t.id_phase = rtc_pkg::PH_TAIL;
          end else begin
            t.id_phase = rtc_pkg::PH_DEAD;
          end
        end
        default: t.id_phase = rtc_pkg::PH_DEAD;
      endcase
      matchers = t;
    end
  endfunction

  // Expected result word for one character; the final one implies a newline
  function automatic token_word_t classify_char(input logic [7:0] c, input logic l);
    token_word_t w;
    logic        joins;
    logic        closes;
    logic [3:0]  kind_code;
    logic        joins_nl;
    logic        closes_nl;
    logic [3:0]  kind_nl;
    absorb_char(c, joins, closes, kind_code);
    if (l) begin
      absorb_char(CH_LF, joins_nl, closes_nl, kind_nl);
      if (closes_nl) begin
        closes    = 1'b1;
        kind_code = kind_nl;
      end
      clear_predictor();
    end
    w.ch_out     = c;
    w.append     = joins;
    w.token_end  = closes;
    w.token_type = closes ? kind_code : rtc_pkg::TOK_NULL;
    return w;
  endfunction

  function automatic string word_text(token_word_t w);
    return $sformatf("ch=%02h append=%0b token_end=%0b token_type=%0d",
                     w.ch_out, w.append, w.token_end, w.token_type);
  endfunction

  function automatic void log_mismatch(string what, token_word_t want, token_word_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected %s, got %s", $time, what, word_text(want), word_text(got));
    end
  endfunction

  // Random text generation into phrase
  function automatic logic [7:0] head_char();
    case ($urandom_range(2))
      0:       return 8'("a" + $urandom_range(25));
      1:       return 8'("A" + $urandom_range(25));
      default: return "_";
    endcase
  endfunction

  // Add one character to the end of the phrase
  function automatic void put_char(logic [7:0] c);
    phrase = {phrase, c};
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) begin
      put_char(s[i]);
    end
  endfunction

  function automatic void add_ident();
    int n;
    n = $urandom_range(3);
    put_char(head_char());
    repeat (n) begin
      put_char($urandom_range(1) ? head_char() : 8'("0" + $urandom_range(9)));
    end
  endfunction

  // Build one token of a random kind plus its separator, which may be left out when it ends the input
  function automatic void make_phrase(output bit close_input);
    int    n;
    string ops;
    string cmp;
    string mix;
    ops = "-+*/^";
    cmp = "=!><";
    mix = "%=$.+-*/^!<>_a9";
    phrase.delete();
    case ($urandom_range(15))
      0: begin
        n = $urandom_range(1, 4);
        repeat (n) put_char(8'("0" + $urandom_range(9)));
      end
      1: begin
        push_text("%");
        add_ident();
      end
      2: begin
        // keyword, or a near miss that falls back to an identifier
        push_text("en");
        if ($urandom_range(3) != 0) push_text("d");
        if ($urandom_range(3) == 0) put_char(head_char());
      end
      3: begin
        add_ident();
        push_text("$");
      end
      4: begin
        push_text("$");
        add_ident();
        push_text("$");
      end
      5: begin
        push_text("=");
        add_ident();
      end
      6: begin
        push_text("=$");
        add_ident();
      end
      7: begin
        push_text("$");
        add_ident();
      end
      8: add_ident();
      9: begin
        if ($urandom_range(1)) begin
          put_char(ops[$urandom_range(4)]);
        end else begin
          put_char(cmp[$urandom_range(3)]);
          if ($urandom_range(3) != 0) push_text("=");
        end
      end
      10: begin
        push_text(".");
        add_ident();
      end
      11, 12: begin
        // quoted text with escaped quotes and blanks inside
        put_char(CH_QUOTE);
        n = $urandom_range(5);
        repeat (n) begin
          case ($urandom_range(5))
            0: push_text("\\\"");
            1: put_char(CH_SP);
            2: put_char(CH_TAB);
            3: begin
              put_char(CH_BSLASH);
              put_char(head_char());
            end
            default: put_char(head_char());
          endcase
        end
        put_char(CH_QUOTE);
        if ($urandom_range(3) == 0) add_ident();
      end
      13: begin
        n = $urandom_range(1, 4);
        repeat (n) put_char(8'($urandom_range(255)));
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) put_char(mix[$urandom_range(mix.len() - 1)]);
      end
    endcase
    close_input = ($urandom_range(7) == 0);
    // Separate with blanks; sometimes let the final word close the token itself
    if (!close_input || $urandom_range(1)) begin
      n = $urandom_range(1, 2);
      repeat (n) begin
        case ($urandom_range(3))
          0:       put_char(CH_SP);
          1:       put_char(CH_TAB);
          2:       put_char(CH_CR);
          default: put_char(CH_LF);
        endcase
      end
    end
  endfunction

  // Offer one character word, hold it until taken, then record its result
  task automatic send_char(input logic [7:0] c, input logic l);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      char_in.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    char_in.valid <= 1'b1;
    char_in.ch    <= c;
    char_in.last  <= l;
    do @(posedge clk); while (!char_in.ready);
    expected_words = {expected_words, classify_char(c, l)};
  endtask

  task automatic send_text(input string s, input bit close_input);
    foreach (s[i]) begin
      send_char(s[i], close_input && (i == s.len() - 1));
    end
  endtask

  // Empty quotes, escaped quote with a blank inside, unterminated string
  task automatic test_string_rules();
    send_text("\"\"x ", 1'b0);
    send_text("\"\\\" \"\n", 1'b0);
    send_text("\"q", 1'b1);
  endtask

  // Byte extremes form a Null token; a final blank with nothing open
  task automatic test_field_extremes();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_CR, 1'b1);
  endtask

  // Tokens closed only by the implied newline of the final word
  task automatic test_end_of_input();
    send_text("end", 1'b1);
    send_text(".b", 1'b1);
  endtask

  task automatic test_random_text(input int count, input int idle_pct, input int stall_pct);
    int sent;
    bit close_input;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      make_phrase(close_input);
      foreach (phrase[i]) begin
        send_char(phrase[i], close_input && (i == phrase.size() - 1));
      end
      sent += phrase.size();
    end
  endtask

  // Hold off the receiver while words keep coming so the input stalls
  task automatic test_input_stall();
    -> hold_off_go;
    test_random_text(40, 0, 0);
  endtask

  // Long receiver hold-off, counted in cycles
  initial begin
    hold_active <= 1'b0;
    forever begin
      @(hold_off_go);
      hold_active <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // Take result words, compare with the oldest expectation, drive ready
  initial begin
    token_word_t want;
    token_word_t got;
    token_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && token_out.valid && token_out.ready) begin
        got.ch_out     = token_out.ch_out;
        got.append     = token_out.append;
        got.token_end  = token_out.token_end;
        got.token_type = token_out.token_type;
        if (expected_words.size() == 0) begin
          log_mismatch("unexpected result word", '0, got);
        end else begin
          want = expected_words.pop_front();
          if (want.ch_out !== got.ch_out || want.append !== got.append ||
              want.token_end !== got.token_end || want.token_type !== got.token_type) begin
            log_mismatch("result word", want, got);
          end
        end
      end
      token_out.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    int spins;
    rst           <= 1'b1;
    char_in.valid <= 1'b0;
    char_in.ch    <= 8'h00;
    char_in.last  <= 1'b0;
    clear_predictor();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_string_rules();
    test_field_extremes();
    test_end_of_input();
    test_random_text(225, 0, 0);
    test_random_text(225, 75, 0);
    test_random_text(225, 0, 75);
    test_random_text(225, 24, 24);
    test_input_stall();

    // Drain outstanding results, then allow for the pipeline latency
    char_in.valid <= 1'b0;
    recv_stall_pct = 0;
    spins = 0;
    while (expected_words.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (expected_words.size() != 0) begin
      log_mismatch("missing result word", expected_words.pop_front(), '0);
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
